### rtl/core/timed_track_motion_sequencer_macros.svh
// Assertion macros used by the datapath (ttms_dp) of the timed track motion sequencer.
// Checks are compiled only when SYNTHESIS is not defined.
`ifndef TIMED_TRACK_MOTION_SEQUENCER_MACROS_SVH
`define TIMED_TRACK_MOTION_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS
`define TTMS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("ttms assertion failed");
`define TTMS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ttms implication failed");
`else
`define TTMS_ASSERT(lbl, prop)
`define TTMS_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

### rtl/core/ttms_pkg.sv
// Package of the timed track motion sequencer: widths, codes and the microprogram.
// Used by the interfaces, the RTL modules and the testbench of the block.
package ttms_pkg;

    localparam int MS_BITS        = 16;
    localparam int RUN_BITS       = 16;
    localparam int TRACK_BITS     = 20;
    localparam int ELAPSED_BITS   = 32;
    localparam int LIMIT_BITS     = 26;
    localparam int PROD_BITS      = LIMIT_BITS + TRACK_BITS;
    localparam int DIV_CNT_BITS   = $clog2(TRACK_BITS + 1);
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 20;
    localparam int PHASE_BITS     = 2;
    localparam int UPC_BITS       = 5;
    localparam int OP_BITS        = 4;
    localparam int COND_BITS      = 4;

    localparam int POSITION_BITS_DEF      = 20;
    localparam int HOME_BACKOFF_STEPS_DEF = 20;

    localparam logic [LIMIT_BITS-1:0] MS_PER_S       = LIMIT_BITS'(1000);
    localparam logic [LIMIT_BITS-1:0] RUN_MS_RESET   = LIMIT_BITS'(3600 * 1000);
    localparam logic [LIMIT_BITS-1:0] DELAY_MS_RESET = LIMIT_BITS'(60 * 1000);
    localparam logic [TRACK_BITS-1:0] TOTAL_RESET    = TRACK_BITS'(10000);

    localparam logic [CFG_IDX_BITS-1:0] REG_RUN_SECONDS   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DELAY_SECONDS = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_TOTAL_STEPS   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_CW_FORWARD    = 2'd3;

    localparam logic [PHASE_BITS-1:0] PH_SEARCH = 2'd0;
    localparam logic [PHASE_BITS-1:0] PH_FWD    = 2'd1;
    localparam logic [PHASE_BITS-1:0] PH_RETURN = 2'd2;
    localparam logic [PHASE_BITS-1:0] PH_WAIT   = 2'd3;

    localparam logic [OP_BITS-1:0] OP_NONE        = 4'd0;
    localparam logic [OP_BITS-1:0] OP_ACCEPT      = 4'd1;
    localparam logic [OP_BITS-1:0] OP_MUL         = 4'd2;
    localparam logic [OP_BITS-1:0] OP_DIV_INIT    = 4'd3;
    localparam logic [OP_BITS-1:0] OP_DIV_STEP    = 4'd4;
    localparam logic [OP_BITS-1:0] OP_FWD_UPD     = 4'd5;
    localparam logic [OP_BITS-1:0] OP_SEARCH_BACK = 4'd6;
    localparam logic [OP_BITS-1:0] OP_RET_BACK    = 4'd7;
    localparam logic [OP_BITS-1:0] OP_GO_RET      = 4'd8;
    localparam logic [OP_BITS-1:0] OP_GO_FWD      = 4'd9;
    localparam logic [OP_BITS-1:0] OP_GO_WAIT     = 4'd10;
    localparam logic [OP_BITS-1:0] OP_EMIT        = 4'd11;

    localparam logic [COND_BITS-1:0] C_NEVER      = 4'd0;
    localparam logic [COND_BITS-1:0] C_ALWAYS     = 4'd1;
    localparam logic [COND_BITS-1:0] C_NO_IN      = 4'd2;
    localparam logic [COND_BITS-1:0] C_PH0        = 4'd3;
    localparam logic [COND_BITS-1:0] C_PH2        = 4'd4;
    localparam logic [COND_BITS-1:0] C_PH3        = 4'd5;
    localparam logic [COND_BITS-1:0] C_OVER       = 4'd6;
    localparam logic [COND_BITS-1:0] C_END        = 4'd7;
    localparam logic [COND_BITS-1:0] C_DIV_MORE   = 4'd8;
    localparam logic [COND_BITS-1:0] C_HOME       = 4'd9;
    localparam logic [COND_BITS-1:0] C_DELAY_OVER = 4'd10;
    localparam logic [COND_BITS-1:0] C_OUT_BUSY   = 4'd11;

    localparam logic [UPC_BITS-1:0] A_IDLE     = 5'd0;
    localparam logic [UPC_BITS-1:0] A_DISP0    = 5'd1;
    localparam logic [UPC_BITS-1:0] A_DISP2    = 5'd2;
    localparam logic [UPC_BITS-1:0] A_DISP3    = 5'd3;
    localparam logic [UPC_BITS-1:0] A_FWD      = 5'd4;
    localparam logic [UPC_BITS-1:0] A_FWD_END  = 5'd5;
    localparam logic [UPC_BITS-1:0] A_FWD_MUL  = 5'd6;
    localparam logic [UPC_BITS-1:0] A_FWD_DIVI = 5'd7;
    localparam logic [UPC_BITS-1:0] A_FWD_DIV  = 5'd8;
    localparam logic [UPC_BITS-1:0] A_FWD_UPD  = 5'd9;
    localparam logic [UPC_BITS-1:0] A_SEARCH   = 5'd10;
    localparam logic [UPC_BITS-1:0] A_SRCH_BK  = 5'd11;
    localparam logic [UPC_BITS-1:0] A_RETURN   = 5'd12;
    localparam logic [UPC_BITS-1:0] A_RET_BK   = 5'd13;
    localparam logic [UPC_BITS-1:0] A_WAIT     = 5'd14;
    localparam logic [UPC_BITS-1:0] A_WAIT_NO  = 5'd15;
    localparam logic [UPC_BITS-1:0] A_TO_RET   = 5'd16;
    localparam logic [UPC_BITS-1:0] A_TO_FWD   = 5'd17;
    localparam logic [UPC_BITS-1:0] A_TO_WAIT  = 5'd18;
    localparam logic [UPC_BITS-1:0] A_EMIT     = 5'd19;

    typedef struct packed {
        logic [OP_BITS-1:0]   op;
        logic [COND_BITS-1:0] cond;
        logic [UPC_BITS-1:0]  target;
        logic                 last;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic ph0;
        logic ph2;
        logic ph3;
        logic over;
        logic end_hit;
        logic div_more;
        logic home;
        logic delay_over;
        logic out_busy;
    } t_stat;

    function automatic t_ctrl uword(input logic [OP_BITS-1:0] op,
                                    input logic [COND_BITS-1:0] cond,
                                    input logic [UPC_BITS-1:0] target,
                                    input logic last);
        t_ctrl w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        w.last   = last;
        return w;
    endfunction

    function automatic t_ctrl ucode_rom(input logic [UPC_BITS-1:0] addr);
        t_ctrl w;
        case (addr)
            A_IDLE:     w = uword(OP_ACCEPT,      C_NO_IN,      A_IDLE,     1'b0);
            A_DISP0:    w = uword(OP_NONE,        C_PH0,        A_SEARCH,   1'b0);
            A_DISP2:    w = uword(OP_NONE,        C_PH2,        A_RETURN,   1'b0);
            A_DISP3:    w = uword(OP_NONE,        C_PH3,        A_WAIT,     1'b0);
            A_FWD:      w = uword(OP_NONE,        C_OVER,       A_TO_RET,   1'b0);
            A_FWD_END:  w = uword(OP_NONE,        C_END,        A_EMIT,     1'b0);
            A_FWD_MUL:  w = uword(OP_MUL,         C_NEVER,      A_IDLE,     1'b0);
            A_FWD_DIVI: w = uword(OP_DIV_INIT,    C_NEVER,      A_IDLE,     1'b0);
            A_FWD_DIV:  w = uword(OP_DIV_STEP,    C_DIV_MORE,   A_FWD_DIV,  1'b0);
            A_FWD_UPD:  w = uword(OP_FWD_UPD,     C_ALWAYS,     A_EMIT,     1'b0);
            A_SEARCH:   w = uword(OP_NONE,        C_HOME,       A_TO_FWD,   1'b0);
            A_SRCH_BK:  w = uword(OP_SEARCH_BACK, C_ALWAYS,     A_EMIT,     1'b0);
            A_RETURN:   w = uword(OP_NONE,        C_HOME,       A_TO_WAIT,  1'b0);
            A_RET_BK:   w = uword(OP_RET_BACK,    C_ALWAYS,     A_EMIT,     1'b0);
            A_WAIT:     w = uword(OP_NONE,        C_DELAY_OVER, A_TO_FWD,   1'b0);
            A_WAIT_NO:  w = uword(OP_NONE,        C_ALWAYS,     A_EMIT,     1'b0);
            A_TO_RET:   w = uword(OP_GO_RET,      C_ALWAYS,     A_EMIT,     1'b0);
            A_TO_FWD:   w = uword(OP_GO_FWD,      C_ALWAYS,     A_EMIT,     1'b0);
            A_TO_WAIT:  w = uword(OP_GO_WAIT,     C_ALWAYS,     A_EMIT,     1'b0);
            A_EMIT:     w = uword(OP_EMIT,        C_OUT_BUSY,   A_EMIT,     1'b1);
            default:    w = uword(OP_NONE,        C_ALWAYS,     A_IDLE,     1'b0);
        endcase
        return w;
    endfunction

endpackage

### rtl/core/ttms_if.sv
// Handshake channels of the timed track motion sequencer: poll, result and configuration.
// Depends on ttms_pkg for the field widths.
interface ttms_poll_if import ttms_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [MS_BITS-1:0]   ms_passed;
    logic                 home_reached;
    logic                 end_reached;
    modport source (output valid, ms_passed, home_reached, end_reached, input ready);
    modport sink   (input valid, ms_passed, home_reached, end_reached, output ready);
endinterface

interface ttms_result_if import ttms_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [TRACK_BITS-1:0] step_count;
    logic                  motor_clockwise;
    logic                  light_on;
    logic [PHASE_BITS-1:0] phase_now;
    logic [TRACK_BITS-1:0] carriage_position;
    modport source (output valid, step_count, motor_clockwise, light_on, phase_now,
                    carriage_position, input ready);
    modport sink   (input valid, step_count, motor_clockwise, light_on, phase_now,
                    carriage_position, output ready);
endinterface

interface ttms_cfg_if import ttms_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/ttms_div.sv
// Restoring divider, one quotient bit per step, for the forward sweep target.
// Depends on ttms_pkg; the quotient is known to fit in TRACK_BITS.
module ttms_div import ttms_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  logic                    i_step,
    input  logic [PROD_BITS-1:0]    i_dividend,
    input  logic [LIMIT_BITS-1:0]   i_divisor,
    output logic [TRACK_BITS-1:0]   o_quot,
    output logic                    o_more
);

    logic [LIMIT_BITS-1:0]   r_rem, n_rem;
    logic [TRACK_BITS-1:0]   r_q, n_q;
    logic [DIV_CNT_BITS-1:0] r_cnt, n_cnt;
    logic [LIMIT_BITS:0]     trial;
    logic [LIMIT_BITS:0]     diff;
    logic                    ge;

    always_comb begin
        trial = {r_rem, r_q[TRACK_BITS-1]};
        diff  = trial - {1'b0, i_divisor};
        ge    = trial >= {1'b0, i_divisor};
        n_rem = r_rem;
        n_q   = r_q;
        n_cnt = r_cnt;
        if (i_load) begin
            n_rem = i_dividend[PROD_BITS-1:TRACK_BITS];
            n_q   = i_dividend[TRACK_BITS-1:0];
            n_cnt = DIV_CNT_BITS'(TRACK_BITS);
        end else if (i_step) begin
            n_rem = ge ? diff[LIMIT_BITS-1:0] : trial[LIMIT_BITS-1:0];
            n_q   = {r_q[TRACK_BITS-2:0], ge};
            n_cnt = r_cnt - DIV_CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_q   <= n_q;
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_quot = r_q;
    assign o_more = r_cnt != DIV_CNT_BITS'(1);

endmodule

### rtl/core/ttms_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
// Depends on ttms_pkg for the control word, the status bundle and the program.
module ttms_seq import ttms_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    logic [UPC_BITS-1:0] r_upc, n_upc;
    t_ctrl               word;
    logic                taken;

    always_comb begin
        word = ucode_rom(r_upc);
        case (word.cond)
            C_NEVER:      taken = 1'b0;
            C_ALWAYS:     taken = 1'b1;
            C_NO_IN:      taken = !i_stat.in_valid;
            C_PH0:        taken = i_stat.ph0;
            C_PH2:        taken = i_stat.ph2;
            C_PH3:        taken = i_stat.ph3;
            C_OVER:       taken = i_stat.over;
            C_END:        taken = i_stat.end_hit;
            C_DIV_MORE:   taken = i_stat.div_more;
            C_HOME:       taken = i_stat.home;
            C_DELAY_OVER: taken = i_stat.delay_over;
            C_OUT_BUSY:   taken = i_stat.out_busy;
            default:      taken = 1'b0;
        endcase
        if (taken) begin
            n_upc = word.target;
        end else if (word.last) begin
            n_upc = A_IDLE;
        end else begin
            n_upc = r_upc + UPC_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= A_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_ctrl = word;

endmodule

### rtl/core/ttms_dp.sv
// Datapath: configuration, phase state, multiply and divide, output register.
// Depends on ttms_pkg, the channel interfaces, ttms_div and the assertion macros.
`include "timed_track_motion_sequencer_macros.svh"

module ttms_dp import ttms_pkg::*; #(
    parameter int POSITION_BITS      = POSITION_BITS_DEF,
    parameter int HOME_BACKOFF_STEPS = HOME_BACKOFF_STEPS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_ctrl         i_ctrl,
    output t_stat         o_stat,
    ttms_poll_if.sink     i_poll,
    ttms_result_if.source o_result,
    ttms_cfg_if.sink      i_cfg
);

    localparam int CMP_BITS = (POSITION_BITS > TRACK_BITS) ? POSITION_BITS : TRACK_BITS;

    logic [LIMIT_BITS-1:0]    r_limit_ms;
    logic [LIMIT_BITS-1:0]    r_delay_ms;
    logic [TRACK_BITS-1:0]    r_total;
    logic                     r_cw_fwd;

    logic [PHASE_BITS-1:0]    r_phase, n_phase;
    logic [ELAPSED_BITS-1:0]  r_elapsed, n_elapsed;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic                     r_lamp, n_lamp;
    logic [TRACK_BITS-1:0]    r_steps, n_steps;
    logic                     r_dir, n_dir;
    logic                     r_home, r_end;
    logic [PROD_BITS-1:0]     r_prod;

    logic                     r_out_valid;
    logic [TRACK_BITS-1:0]    r_out_steps;
    logic                     r_out_dir;
    logic                     r_out_lamp;
    logic [PHASE_BITS-1:0]    r_out_phase;
    logic [TRACK_BITS-1:0]    r_out_pos;

    logic                     accept;
    logic                     out_busy;
    logic                     emit;
    logic [ELAPSED_BITS:0]    elapsed_sum;
    logic [TRACK_BITS-1:0]    quot;
    logic                     div_more;
    logic [CMP_BITS-1:0]      tgt_ext;
    logic [CMP_BITS-1:0]      pos_ext;
    logic [CMP_BITS-1:0]      step_diff;

    ttms_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (i_ctrl.op == OP_DIV_INIT),
        .i_step     (i_ctrl.op == OP_DIV_STEP),
        .i_dividend (r_prod),
        .i_divisor  (r_limit_ms),
        .o_quot     (quot),
        .o_more     (div_more)
    );

    assign i_cfg.ready  = 1'b1;
    assign i_poll.ready = i_ctrl.op == OP_ACCEPT;
    assign accept       = i_poll.valid && (i_ctrl.op == OP_ACCEPT);
    assign out_busy     = r_out_valid && !o_result.ready;
    assign emit         = (i_ctrl.op == OP_EMIT) && !out_busy;

    always_comb begin
        elapsed_sum = {1'b0, r_elapsed} + (ELAPSED_BITS + 1)'(i_poll.ms_passed);
        tgt_ext     = (r_limit_ms == '0) ? '0 : CMP_BITS'(quot);
        pos_ext     = CMP_BITS'(r_pos);
        step_diff   = tgt_ext - pos_ext;

        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_pos     = r_pos;
        n_lamp    = r_lamp;
        n_steps   = r_steps;
        n_dir     = r_dir;
        case (i_ctrl.op)
            OP_ACCEPT: begin
                if (accept) begin
                    n_elapsed = elapsed_sum[ELAPSED_BITS] ? '1
                                                          : elapsed_sum[ELAPSED_BITS-1:0];
                    n_steps   = '0;
                    n_dir     = 1'b0;
                end
            end
            OP_FWD_UPD: begin
                if (tgt_ext > pos_ext) begin
                    n_steps = step_diff[TRACK_BITS-1:0];
                    n_dir   = r_cw_fwd;
                    n_pos   = tgt_ext[POSITION_BITS-1:0];
                end
            end
            OP_SEARCH_BACK: begin
                n_steps = TRACK_BITS'(1);
                n_dir   = !r_cw_fwd;
            end
            OP_RET_BACK: begin
                if (r_pos != '0) begin
                    n_pos = r_pos - POSITION_BITS'(1);
                end
                n_steps = TRACK_BITS'(1);
                n_dir   = !r_cw_fwd;
            end
            OP_GO_RET: begin
                n_phase   = PH_RETURN;
                n_elapsed = '0;
                n_lamp    = 1'b0;
            end
            OP_GO_FWD: begin
                n_phase   = PH_FWD;
                n_elapsed = '0;
                n_lamp    = 1'b1;
            end
            OP_GO_WAIT: begin
                n_phase   = PH_WAIT;
                n_elapsed = '0;
                n_pos     = POSITION_BITS'(HOME_BACKOFF_STEPS);
                n_steps   = TRACK_BITS'(HOME_BACKOFF_STEPS);
                n_dir     = r_cw_fwd;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_steps <= n_steps;
        r_dir   <= n_dir;
        if (accept) begin
            r_home <= i_poll.home_reached;
            r_end  <= i_poll.end_reached;
        end
        if (i_ctrl.op == OP_MUL) begin
            r_prod <= PROD_BITS'(r_elapsed[LIMIT_BITS-1:0]) * PROD_BITS'(r_total);
        end
        if (emit) begin
            r_out_steps <= r_steps;
            r_out_dir   <= r_dir && (r_steps != '0);
            r_out_lamp  <= r_lamp;
            r_out_phase <= r_phase;
            r_out_pos   <= pos_ext[TRACK_BITS-1:0];
        end
        if (!i_rst_n) begin
            r_limit_ms  <= RUN_MS_RESET;
            r_delay_ms  <= DELAY_MS_RESET;
            r_total     <= TOTAL_RESET;
            r_cw_fwd    <= 1'b1;
            r_phase     <= PH_SEARCH;
            r_elapsed   <= '0;
            r_pos       <= '0;
            r_lamp      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_pos     <= n_pos;
            r_lamp    <= n_lamp;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_RUN_SECONDS:
                        r_limit_ms <= LIMIT_BITS'(i_cfg.data[RUN_BITS-1:0]) * MS_PER_S;
                    REG_DELAY_SECONDS:
                        r_delay_ms <= LIMIT_BITS'(i_cfg.data[RUN_BITS-1:0]) * MS_PER_S;
                    REG_TOTAL_STEPS:
                        r_total <= i_cfg.data[TRACK_BITS-1:0];
                    REG_CW_FORWARD:
                        r_cw_fwd <= i_cfg.data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_stat.in_valid   = i_poll.valid;
        o_stat.ph0        = r_phase == PH_SEARCH;
        o_stat.ph2        = r_phase == PH_RETURN;
        o_stat.ph3        = r_phase == PH_WAIT;
        o_stat.over       = r_elapsed > ELAPSED_BITS'(r_limit_ms);
        o_stat.end_hit    = r_end;
        o_stat.div_more   = div_more;
        o_stat.home       = r_home;
        o_stat.delay_over = r_elapsed > ELAPSED_BITS'(r_delay_ms);
        o_stat.out_busy   = out_busy;
    end

    assign o_result.valid             = r_out_valid;
    assign o_result.step_count        = r_out_steps;
    assign o_result.motor_clockwise   = r_out_dir;
    assign o_result.light_on          = r_out_lamp;
    assign o_result.phase_now         = r_out_phase;
    assign o_result.carriage_position = r_out_pos;

    `TTMS_ASSERT(a_lamp_follows_phase, r_lamp == (r_phase == PH_FWD))
    `TTMS_ASSERT_IMP(a_phase_change_clears_time, r_phase != $past(r_phase), r_elapsed == '0)
    `TTMS_ASSERT_IMP(a_idle_dir_zero, r_out_valid && (r_out_steps == '0), !r_out_dir)

endmodule

### rtl/core/timed_track_motion_sequencer.sv
// Top level of the timed track motion sequencer.
// Depends on ttms_pkg, the channel interfaces, ttms_seq and ttms_dp.
//
// One poll item goes in and one result item comes out for it. A forward sweep poll that
// computes a new target runs the 20-step restoring divider, which computes
// elapsed*total_track_steps/(run_seconds*1000) one quotient bit a cycle. A result that is
// not taken holds the sequencer at its output step. A new poll is taken as soon as the
// previous result sits in the output register. Configuration writes are accepted at
// every cycle and take effect at once; write them only while no poll is in flight.
module timed_track_motion_sequencer import ttms_pkg::*; #(
    parameter int POSITION_BITS      = POSITION_BITS_DEF,
    parameter int HOME_BACKOFF_STEPS = HOME_BACKOFF_STEPS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ttms_poll_if.sink     i_poll,
    ttms_result_if.source o_result,
    ttms_cfg_if.sink      i_cfg
);

    t_ctrl ctrl;
    t_stat stat;

    ttms_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    ttms_dp #(
        .POSITION_BITS      (POSITION_BITS),
        .HOME_BACKOFF_STEPS (HOME_BACKOFF_STEPS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .o_stat   (stat),
        .i_poll   (i_poll),
        .o_result (o_result),
        .i_cfg    (i_cfg)
    );

endmodule

### test/tb_timed_track_motion_sequencer.sv
// Testbench of timed_track_motion_sequencer: drives poll items, checks each result item
// against an in-bench model of the four-phase carriage sequence, and rewrites the settings.
// Depends on ttms_pkg, the channel interfaces and the RTL of the block.
module tb_timed_track_motion_sequencer import ttms_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 800000;
    localparam int POLL_TARGET  = 1270;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [MS_BITS-1:0] ms;
        logic               at_home;
        logic               at_far;
    } t_poll;

    typedef struct packed {
        logic [TRACK_BITS-1:0] steps;
        logic                  cw;
        logic                  lamp;
        logic [PHASE_BITS-1:0] phase;
        logic [TRACK_BITS-1:0] pos;
    } t_track_result;

    logic i_clk;
    logic i_rst_n;

    ttms_poll_if   poll_ch ();
    ttms_result_if result_ch ();
    ttms_cfg_if    cfg_ch ();

    timed_track_motion_sequencer u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_poll   (poll_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    logic [RUN_BITS-1:0]     run_s;
    logic [RUN_BITS-1:0]     delay_s;
    logic [TRACK_BITS-1:0]   track_steps;
    logic                    cw_fwd;
    logic [PHASE_BITS-1:0]   sweep_phase;
    logic [ELAPSED_BITS-1:0] phase_ms;
    logic [TRACK_BITS-1:0]   carriage_pos;
    logic                    lamp_lit;

    t_poll         pending_polls[$];
    t_track_result expected_results[$];
    int            polls_in_flight;
    int            polls_queued;
    int            bad_results;
    int            noise_pct;
    int            cycle_count = 0;
    bit            calm;

    function automatic t_track_result advance_track(input t_poll p);
        t_track_result r;
        logic [ELAPSED_BITS:0] sum;
        logic [63:0] limit_ms;
        logic [63:0] target;
        r = '0;
        sum = {1'b0, phase_ms} + (ELAPSED_BITS + 1)'(p.ms);
        phase_ms = sum[ELAPSED_BITS] ? '1 : sum[ELAPSED_BITS-1:0];
        case (sweep_phase)
            PH_SEARCH: begin
                if (p.at_home) begin
                    sweep_phase = PH_FWD;
                    phase_ms = '0;
                    lamp_lit = 1'b1;
                end else begin
                    r.steps = TRACK_BITS'(1);
                    r.cw = ~cw_fwd;
                end
            end
            PH_FWD: begin
                limit_ms = 64'(run_s) * 64'(MS_PER_S);
                if (64'(phase_ms) > limit_ms) begin
                    sweep_phase = PH_RETURN;
                    phase_ms = '0;
                    lamp_lit = 1'b0;
                end else if (!p.at_far) begin
                    target = (limit_ms == 0) ? 64'd0
                           : (64'(phase_ms) * 64'(track_steps)) / limit_ms;
                    if (target > 64'(carriage_pos)) begin
                        r.steps = TRACK_BITS'(target - 64'(carriage_pos));
                        r.cw = cw_fwd;
                        carriage_pos = TRACK_BITS'(target);
                    end
                end
            end
            PH_RETURN: begin
                if (p.at_home) begin
                    sweep_phase = PH_WAIT;
                    phase_ms = '0;
                    carriage_pos = TRACK_BITS'(HOME_BACKOFF_STEPS_DEF);
                    r.steps = TRACK_BITS'(HOME_BACKOFF_STEPS_DEF);
                    r.cw = cw_fwd;
                end else begin
                    if (carriage_pos != '0)
                        carriage_pos = carriage_pos - TRACK_BITS'(1);
                    r.steps = TRACK_BITS'(1);
                    r.cw = ~cw_fwd;
                end
            end
            default: begin
                if (64'(phase_ms) > 64'(delay_s) * 64'(MS_PER_S)) begin
                    sweep_phase = PH_FWD;
                    phase_ms = '0;
                    lamp_lit = 1'b1;
                end
            end
        endcase
        if (r.steps == '0)
            r.cw = 1'b0;
        r.lamp = lamp_lit;
        r.phase = sweep_phase;
        r.pos = carriage_pos;
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_poll next;
        if (!i_rst_n) begin
            poll_ch.valid <= 1'b0;
        end else begin
            if (poll_ch.valid && poll_ch.ready) begin
                next.ms = poll_ch.ms_passed;
                next.at_home = poll_ch.home_reached;
                next.at_far = poll_ch.end_reached;
                expected_results.push_back(advance_track(next));
            end
            if (!poll_ch.valid || poll_ch.ready) begin
                if (pending_polls.size() > 0 && (calm || $urandom_range(99) >= 17)) begin
                    next = pending_polls.pop_front();
                    poll_ch.valid <= 1'b1;
                    poll_ch.ms_passed <= next.ms;
                    poll_ch.home_reached <= next.at_home;
                    poll_ch.end_reached <= next.at_far;
                end else begin
                    poll_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_track_result want;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (expected_results.size() == 0) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("unexpected result item: steps=%0d pos=%0d phase=%0d",
                                 result_ch.step_count, result_ch.carriage_position,
                                 result_ch.phase_now);
                end else begin
                    want = expected_results.pop_front();
                    polls_in_flight--;
                    if (result_ch.step_count !== want.steps
                            || result_ch.motor_clockwise !== want.cw
                            || result_ch.light_on !== want.lamp
                            || result_ch.phase_now !== want.phase
                            || result_ch.carriage_position !== want.pos) begin
                        bad_results++;
                        if (bad_results <= 10) begin
                            $write("mismatch: expected steps=%0d cw=%0b lamp=%0b phase=%0d pos=%0d",
                                   want.steps, want.cw, want.lamp, want.phase, want.pos);
                            $display(", got steps=%0d cw=%0b lamp=%0b phase=%0d pos=%0d",
                                     result_ch.step_count, result_ch.motor_clockwise,
                                     result_ch.light_on, result_ch.phase_now,
                                     result_ch.carriage_position);
                        end
                    end
                end
            end
            result_ch.ready <= calm || $urandom_range(99) >= 17;
        end
    end

    task automatic wait_idle();
        while (polls_in_flight != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int value);
        wait_idle();
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= CFG_DATA_BITS'(value);
        do
            @(posedge i_clk);
        while (!cfg_ch.ready);
        case (idx)
            REG_RUN_SECONDS:   run_s = RUN_BITS'(value);
            REG_DELAY_SECONDS: delay_s = RUN_BITS'(value);
            REG_TOTAL_STEPS:   track_steps = TRACK_BITS'(value);
            default:           cw_fwd = value[0];
        endcase
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic add_poll(input int ms, input bit at_home, input bit at_far);
        t_poll p;
        if ($urandom_range(99) < noise_pct) begin
            p.ms = MS_BITS'($urandom_range(65535));
            p.at_home = 1'($urandom_range(1));
            p.at_far = 1'($urandom_range(1));
        end else begin
            p.ms = MS_BITS'(ms);
            p.at_home = at_home;
            p.at_far = at_far;
        end
        pending_polls.push_back(p);
        polls_in_flight++;
        polls_queued++;
    endtask

    function automatic int pace_ms(input longint span_ms, input int lo);
        longint stride;
        stride = span_ms / $urandom_range(3, 25);
        if (stride > 32767)
            stride = 32767;
        return $urandom_range(lo, 2 * int'(stride) + 1);
    endfunction

    task automatic load_settings(input int run, input int delay, input int total, input bit cw);
        write_reg(REG_RUN_SECONDS, run);
        write_reg(REG_DELAY_SECONDS, delay);
        write_reg(REG_TOTAL_STEPS, total);
        write_reg(REG_CW_FORWARD, int'(cw));
    endtask

    task automatic pick_settings();
        case ($urandom_range(5))
            0: load_settings($urandom_range(1, 5), $urandom_range(3), $urandom_range(1, 30),
                             1'($urandom_range(1)));
            1: load_settings($urandom_range(1, 120), $urandom_range(60),
                             $urandom_range(1, 50000), 1'($urandom_range(1)));
            2: load_settings(65535, 65535, 1048575, 1'($urandom_range(1)));
            3: load_settings(1, 0, 1048575, 1'($urandom_range(1)));
            default: load_settings($urandom_range(1, 600), $urandom_range(120),
                                   $urandom_range(100, 1048575), 1'($urandom_range(1)));
        endcase
    endtask

    initial begin
        int n;
        int next_settings;
        i_rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_RUN_SECONDS;
        cfg_ch.data = '0;
        run_s = 16'd3600;
        delay_s = 16'd60;
        track_steps = TOTAL_RESET;
        cw_fwd = 1'b1;
        sweep_phase = PH_SEARCH;
        phase_ms = '0;
        carriage_pos = '0;
        lamp_lit = 1'b0;
        polls_in_flight = 0;
        polls_queued = 0;
        bad_results = 0;
        noise_pct = 0;
        calm = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_poll(0, 0, 0);
        add_poll(65535, 0, 1);
        write_reg(REG_CW_FORWARD, 0);
        add_poll(1, 0, 0);
        add_poll(7, 1, 1);
        write_reg(REG_RUN_SECONDS, 1);
        write_reg(REG_TOTAL_STEPS, 1048575);
        add_poll(0, 0, 0);
        add_poll(999, 0, 1);
        add_poll(1, 0, 0);
        add_poll(1, 0, 0);
        add_poll(3, 0, 0);
        add_poll(65535, 1, 0);
        write_reg(REG_CW_FORWARD, 1);
        write_reg(REG_DELAY_SECONDS, 0);
        add_poll(0, 0, 0);
        add_poll(1, 0, 1);
        write_reg(REG_RUN_SECONDS, 0);
        add_poll(0, 0, 0);
        add_poll(2, 1, 0);
        add_poll(0, 0, 0);
        write_reg(REG_DELAY_SECONDS, 65535);
        write_reg(REG_RUN_SECONDS, 65535);
        add_poll(0, 1, 0);
        add_poll(65535, 0, 0);
        add_poll(65535, 1, 1);
        write_reg(REG_DELAY_SECONDS, 1);
        add_poll(1000, 0, 0);
        add_poll(65535, 0, 0);
        wait_idle();

        noise_pct = 15;
        next_settings = polls_queued;
        while (polls_queued < POLL_TARGET) begin
            if (polls_queued >= next_settings) begin
                pick_settings();
                next_settings = polls_queued + $urandom_range(100, 200);
            end
            calm = polls_queued >= 450 && polls_queued < 700;
            case (sweep_phase)
                PH_FWD: begin
                    n = $urandom_range(4, 12);
                    repeat (n)
                        add_poll(pace_ms(longint'(run_s) * 1000, 0),
                                 $urandom_range(99) < 5, $urandom_range(99) < 10);
                end
                PH_RETURN: begin
                    n = ($urandom_range(4) == 0) ? $urandom_range(10, 40) : $urandom_range(6);
                    repeat (n)
                        add_poll($urandom_range(200), 0, $urandom_range(99) < 10);
                    add_poll($urandom_range(200), 1, $urandom_range(99) < 10);
                end
                PH_WAIT: begin
                    n = $urandom_range(3, 10);
                    repeat (n)
                        add_poll(pace_ms(longint'(delay_s) * 1000, 1),
                                 1'($urandom_range(1)), 1'($urandom_range(1)));
                end
                default: begin
                    n = $urandom_range(5);
                    repeat (n)
                        add_poll($urandom_range(65535), 0, 1'($urandom_range(1)));
                    add_poll($urandom_range(65535), 1, 1'($urandom_range(1)));
                end
            endcase
            wait_idle();
        end
        calm = 1'b0;

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (bad_results == 0 && expected_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### timed_track_motion_sequencer.f
+incdir+rtl/core
rtl/core/ttms_pkg.sv
rtl/core/ttms_if.sv
rtl/core/ttms_div.sv
rtl/core/ttms_seq.sv
rtl/core/ttms_dp.sv
rtl/core/timed_track_motion_sequencer.sv
test/tb_timed_track_motion_sequencer.sv
